FILE: rtl/ptu_pkg.sv
// ----------------------------------------------------------------------------
// ptu_pkg
// Shared types and constants of the pheromone table update engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ptu_pkg;

	localparam int LEVEL_W  = 32;
	localparam int WEIGHT_W = 17;
	localparam int ACC_W    = 49;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 3;
	localparam int OP_W     = 3;

	localparam logic [WEIGHT_W-1:0] ONE_Q16  = 17'd65536;
	localparam logic [ACC_W-1:0]    HALF_Q16 = 49'd32768;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_READ    = 3'd0;
	localparam logic [OP_W-1:0] OP_DEPOSIT = 3'd1;
	localparam logic [OP_W-1:0] OP_ADD     = 3'd2;
	localparam logic [OP_W-1:0] OP_BLEND   = 3'd3;
	localparam logic [OP_W-1:0] OP_CLAMP   = 3'd4;
	localparam logic [OP_W-1:0] OP_FILL    = 3'd5;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_EVAP_RATE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_FLOOR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_CEILING = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOUND_ENABLE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_LEVEL = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_IN_USE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_VALUES_IN_USE = 3'd6;

	// Control of the shared multiply-accumulate unit.
	typedef struct packed {
		logic en;     // perform a multiply-accumulate step
		logic first;  // start from the rounding constant instead of the sum
	} mac_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/pheromone_table_update_engine.sv
// ----------------------------------------------------------------------------
// pheromone_table_update_engine
// Pheromone table of Q16.16 levels with read, deposit, add, blend, clamp
// sweep and fill sweep, driven by a small sequencer around one shared MAC.
// ----------------------------------------------------------------------------
// Steps: read and add finish in S_OP; deposit and blend run S_OP, S_MUL2
// and S_WB (two passes through the shared multiplier); out-of-range or idle
// ops finish at once; sweeps run S_FILL, or S_CLAMP and then S_DRAIN.
// One item at a time: busy stays high until the result is issued, so the
// rate is set by the table port (one entry per cycle) and the MAC passes.
// done pulses for one cycle; the receiver cannot stall it.
// Reset returns control to idle and the registers to their defaults; table
// contents stay undefined.
`default_nettype none

module pheromone_table_update_engine #(
	parameter int MAX_CELLS  = 1024,
	parameter int MAX_VALUES = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [ptu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ptu_pkg::CFG_W-1:0]         cfg_data,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [ptu_pkg::OP_W-1:0]          op,
	input  wire logic [9:0]                        cell_req,
	input  wire logic [4:0]                        value_slot,
	input  wire logic [ptu_pkg::LEVEL_W-1:0]       amount,
	input  wire logic [ptu_pkg::WEIGHT_W-1:0]      mix_weight,
	input  wire logic [ptu_pkg::LEVEL_W-1:0]       partner_level,
	output logic                                   done,
	output logic      [ptu_pkg::LEVEL_W-1:0]       level,
	output logic                                   index_error
);
	import ptu_pkg::*;

	localparam int DEPTH = MAX_CELLS * MAX_VALUES;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = $clog2(MAX_CELLS + 1);
	localparam int CW    = $clog2(MAX_VALUES + 1);
	localparam int RIW   = $clog2(MAX_CELLS);
	localparam int CIW   = $clog2(MAX_VALUES);

	typedef enum logic [2:0] {
		S_IDLE,
		S_OP,
		S_MUL2,
		S_WB,
		S_FILL,
		S_CLAMP,
		S_DRAIN
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [WEIGHT_W-1:0] evap_rate_q;
	logic [LEVEL_W-1:0]  level_floor_q;
	logic [LEVEL_W-1:0]  level_ceiling_q;
	logic                bound_enable_q;
	logic [LEVEL_W-1:0]  initial_level_q;
	logic [10:0]         cells_in_use_q;
	logic [5:0]          values_in_use_q;

	// Latched item fields.
	logic [OP_W-1:0]     op_q;
	logic [AW-1:0]       addr_q;
	logic [LEVEL_W-1:0]  other_q;
	logic [WEIGHT_W-1:0] weight_q;

	// Sweep position and clamp pipeline.
	logic [RIW-1:0]      row_q;
	logic [CIW-1:0]      col_q;
	logic                vld_s1;
	logic [AW-1:0]       addr_s1;

	logic [RW-1:0]       rows_eff;
	logic [CW-1:0]       cols_eff;
	logic                in_range;
	logic [AW-1:0]       req_addr;
	logic [AW-1:0]       sweep_addr;
	logic                sweep_last;
	logic [WEIGHT_W-1:0] rate_eff;
	logic [WEIGHT_W-1:0] mix_eff;
	logic [LEVEL_W:0]    add_sum;
	logic [LEVEL_W-1:0]  add_sat;
	logic [LEVEL_W-1:0]  clamp_val;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [LEVEL_W-1:0]  ram_wdata;
	logic                ram_re;
	logic [AW-1:0]       ram_raddr;
	logic [LEVEL_W-1:0]  ram_rdata;

	mac_ctl_t            mac_ctl;
	logic [LEVEL_W-1:0]  mac_a;
	logic [WEIGHT_W-1:0] mac_b;
	logic [ACC_W-1:0]    mac_acc;

	assign rows_eff = (32'(cells_in_use_q) > 32'(MAX_CELLS)) ? RW'(MAX_CELLS)
	                                                          : RW'(cells_in_use_q);
	assign cols_eff = (32'(values_in_use_q) > 32'(MAX_VALUES)) ? CW'(MAX_VALUES)
	                                                            : CW'(values_in_use_q);
	assign in_range = (32'(cell_req) < 32'(rows_eff)) && (32'(value_slot) < 32'(cols_eff));
	assign req_addr = AW'(32'(cell_req) * 32'(MAX_VALUES) + 32'(value_slot));
	assign sweep_addr = AW'(32'(row_q) * 32'(MAX_VALUES) + 32'(col_q));
	assign sweep_last = (32'(row_q) + 32'd1 == 32'(rows_eff)) &&
	                    (32'(col_q) + 32'd1 == 32'(cols_eff));

	assign rate_eff = (evap_rate_q > ONE_Q16) ? ONE_Q16 : evap_rate_q;
	assign mix_eff  = (mix_weight > ONE_Q16) ? ONE_Q16 : mix_weight;

	assign add_sum = {1'b0, ram_rdata} + {1'b0, other_q};
	assign add_sat = add_sum[LEVEL_W] ? {LEVEL_W{1'b1}} : add_sum[LEVEL_W-1:0];

	// The floor is tested first, so it wins when it lies above the ceiling.
	always_comb begin
		priority if (ram_rdata < level_floor_q) begin
			clamp_val = level_floor_q;
		end else if (ram_rdata > level_ceiling_q) begin
			clamp_val = level_ceiling_q;
		end else begin
			clamp_val = ram_rdata;
		end
	end

	assign busy = (state_q != S_IDLE);

	// Table read port.
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = req_addr;
		if (state_q == S_IDLE) begin
			ram_re = start && in_range && (op <= OP_BLEND);
		end else if (state_q == S_CLAMP) begin
			ram_re    = 1'b1;
			ram_raddr = sweep_addr;
		end
	end

	// Table write port.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = add_sat;
		if (vld_s1) begin
			ram_we    = 1'b1;
			ram_waddr = addr_s1;
			ram_wdata = clamp_val;
		end else if (state_q == S_FILL) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_addr;
			ram_wdata = initial_level_q;
		end else if (state_q == S_WB) begin
			ram_we    = 1'b1;
			ram_wdata = mac_acc[LEVEL_W+15:16];
		end else if (state_q == S_OP && op_q == OP_ADD) begin
			ram_we    = 1'b1;
		end
	end

	// Shared MAC: own*(one-w) first, then partner or amount times w on top.
	always_comb begin
		mac_ctl.en    = 1'b0;
		mac_ctl.first = 1'b0;
		mac_a         = other_q;
		mac_b         = weight_q;
		if (state_q == S_OP) begin
			mac_ctl.en    = (op_q == OP_DEPOSIT) || (op_q == OP_BLEND);
			mac_ctl.first = 1'b1;
			mac_a         = ram_rdata;
			mac_b         = ONE_Q16 - weight_q;
		end else if (state_q == S_MUL2) begin
			mac_ctl.en    = 1'b1;
		end
	end

	ptu_mac u_mac (
		.clk   (clk),
		.ctl   (mac_ctl),
		.mul_a (mac_a),
		.mul_b (mac_b),
		.acc_q (mac_acc)
	);

	ptu_ram #(
		.WIDTH (LEVEL_W),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evap_rate_q     <= 17'd6554;
			level_floor_q   <= '0;
			level_ceiling_q <= '1;
			bound_enable_q  <= 1'b1;
			initial_level_q <= 32'd65536;
			cells_in_use_q  <= 11'd81;
			values_in_use_q <= 6'd9;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EVAP_RATE:     evap_rate_q     <= cfg_data[WEIGHT_W-1:0];
				REG_LEVEL_FLOOR:   level_floor_q   <= cfg_data;
				REG_LEVEL_CEILING: level_ceiling_q <= cfg_data;
				REG_BOUND_ENABLE:  bound_enable_q  <= cfg_data[0];
				REG_INITIAL_LEVEL: initial_level_q <= cfg_data;
				REG_CELLS_IN_USE:  cells_in_use_q  <= cfg_data[10:0];
				REG_VALUES_IN_USE: values_in_use_q <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer with its registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			done        <= 1'b0;
			level       <= '0;
			index_error <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			vld_s1      <= 1'b0;
			addr_s1     <= '0;
			op_q        <= OP_READ;
			addr_q      <= '0;
			other_q     <= '0;
			weight_q    <= '0;
		end else begin
			done    <= 1'b0;
			vld_s1  <= (state_q == S_CLAMP);
			addr_s1 <= sweep_addr;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q        <= op;
						addr_q      <= req_addr;
						other_q     <= (op == OP_BLEND) ? partner_level : amount;
						weight_q    <= (op == OP_BLEND) ? mix_eff : rate_eff;
						level       <= '0;
						index_error <= 1'b0;
						if (op <= OP_BLEND) begin
							if (in_range) begin
								state_q <= S_OP;
							end else begin
								index_error <= 1'b1;
								done        <= 1'b1;
							end
						end else if (op == OP_FILL && rows_eff != '0 && cols_eff != '0) begin
							state_q <= S_FILL;
						end else if (op == OP_CLAMP && bound_enable_q &&
						             rows_eff != '0 && cols_eff != '0) begin
							state_q <= S_CLAMP;
						end else begin
							// Empty sweeps and undefined codes finish at once.
							done <= 1'b1;
						end
					end
				end
				S_OP: begin
					if (op_q == OP_DEPOSIT || op_q == OP_BLEND) begin
						state_q <= S_MUL2;
					end else begin
						level   <= (op_q == OP_ADD) ? add_sat : ram_rdata;
						done    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_MUL2: begin
					state_q <= S_WB;
				end
				S_WB: begin
					level   <= mac_acc[LEVEL_W+15:16];
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				S_FILL, S_CLAMP: begin
					if (sweep_last) begin
						row_q <= '0;
						col_q <= '0;
						if (state_q == S_FILL) begin
							done    <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_DRAIN;
						end
					end else if (32'(col_q) + 32'd1 == 32'(cols_eff)) begin
						col_q <= '0;
						row_q <= row_q + RIW'(1);
					end else begin
						col_q <= col_q + CIW'(1);
					end
				end
				S_DRAIN: begin
					// The last clamped entry is written in this cycle.
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted item neither started nor finished");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !ram_we)
		else $error("table written while idle");

	a_error_level_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && index_error) |-> (level == '0))
		else $error("flagged item returned a nonzero level");

	a_sweep_home: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (row_q == '0 && col_q == '0))
		else $error("sweep position not cleared at idle");

	a_clamp_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == S_CLAMP || state_q == S_DRAIN))
		else $error("clamp write outside of a clamp sweep");

endmodule

`default_nettype wire

FILE: rtl/ptu_ram.sv
// ----------------------------------------------------------------------------
// ptu_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ptu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32768
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/ptu_mac.sv
// ----------------------------------------------------------------------------
// ptu_mac
// Shared multiply-accumulate unit used twice per weighted mix.
// ----------------------------------------------------------------------------
`default_nettype none

module ptu_mac (
	input  wire logic                            clk,
	input  wire ptu_pkg::mac_ctl_t               ctl,
	input  wire logic [ptu_pkg::LEVEL_W-1:0]     mul_a,
	input  wire logic [ptu_pkg::WEIGHT_W-1:0]    mul_b,
	output logic      [ptu_pkg::ACC_W-1:0]       acc_q
);
	import ptu_pkg::*;

	logic [ACC_W-1:0] product;
	logic [ACC_W-1:0] base;

	assign product = ACC_W'(mul_a) * ACC_W'(mul_b);
	// The first step seeds the sum with the half-unit rounding term.
	assign base    = ctl.first ? HALF_Q16 : acc_q;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc_q <= base + product;
		end
	end

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the pheromone table update engine. A shadow copy
// of the table and its registers predicts every result. A short directed part
// covers field extremes, every operation, rate and weight saturation, size
// limits, zero sizes and inverted bounds. Random phases with fresh register
// settings follow, most of them with random idle gaps.
// ----------------------------------------------------------------------------
module tb_top;
	import ptu_pkg::*;

	localparam int MAX_CELLS     = 1024;
	localparam int MAX_VALUES    = 32;
	localparam int TABLE_SIZE    = MAX_CELLS * MAX_VALUES;
	localparam int RESET_CYCLES  = 8;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_LIMIT   = 70000;
	localparam int RANDOM_PHASES = 20;
	localparam int PHASE_ITEMS   = 50;
	localparam int SWEEP_BUDGET  = 2048;
	localparam int MAX_REPORTS   = 10;
	localparam longint CYCLE_LIMIT = 8000000;

	localparam logic [OP_W-1:0]      OP_SPARE_6 = 3'd6;
	localparam logic [OP_W-1:0]      OP_SPARE_7 = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 3'd7;
	localparam logic [LEVEL_W-1:0]   LEVEL_MAX  = '1;
	localparam logic [WEIGHT_W-1:0]  WEIGHT_MAX = '1;

	typedef struct packed {
		logic [OP_W-1:0]     opc;
		logic [9:0]          row_idx;
		logic [4:0]          col_idx;
		logic [LEVEL_W-1:0]  amt;
		logic [WEIGHT_W-1:0] wt;
		logic [LEVEL_W-1:0]  partner;
	} ptu_cmd_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] lvl;
		logic               err;
	} ptu_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 start;
	logic                 busy;
	logic [OP_W-1:0]      op;
	logic [9:0]           cell_req;
	logic [4:0]           value_slot;
	logic [LEVEL_W-1:0]   amount;
	logic [WEIGHT_W-1:0]  mix_weight;
	logic [LEVEL_W-1:0]   partner_level;
	logic                 done;
	logic [LEVEL_W-1:0]   level;
	logic                 index_error;

	pheromone_table_update_engine #(
		.MAX_CELLS (MAX_CELLS),
		.MAX_VALUES(MAX_VALUES)
	) uut (.*);

	// Shadow of the table and the registers.
	logic [LEVEL_W-1:0]  shadow_table [TABLE_SIZE];
	logic [WEIGHT_W-1:0] sh_evap;
	logic [LEVEL_W-1:0]  sh_floor;
	logic [LEVEL_W-1:0]  sh_ceiling;
	logic                sh_bound;
	logic [LEVEL_W-1:0]  sh_init;
	logic [10:0]         sh_cells;
	logic [5:0]          sh_values;

	ptu_result_t pending_levels [$];
	int          fault_count  = 0;
	int          items_sent   = 0;
	int          results_seen = 0;
	int          op_tally [8];
	longint      cycle_count  = 0;
	bit          free_gaps    = 1'b1;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic int rows_now();
		return (sh_cells > MAX_CELLS) ? MAX_CELLS : int'(sh_cells);
	endfunction

	function automatic int cols_now();
		return (sh_values > MAX_VALUES) ? MAX_VALUES : int'(sh_values);
	endfunction

	function automatic logic [LEVEL_W-1:0] mix_level(logic [LEVEL_W-1:0] own,
			logic [LEVEL_W-1:0] other, logic [WEIGHT_W-1:0] w);
		logic [63:0] wt;
		logic [63:0] acc;
		wt  = (w > ONE_Q16) ? 64'(ONE_Q16) : 64'(w);
		acc = 64'(own) * (64'(ONE_Q16) - wt) + 64'(other) * wt + 64'(HALF_Q16);
		return acc[47:16];
	endfunction

	function automatic void reset_shadow();
		sh_evap    = 17'd6554;
		sh_floor   = '0;
		sh_ceiling = LEVEL_MAX;
		sh_bound   = 1'b1;
		sh_init    = 32'd65536;
		sh_cells   = 11'd81;
		sh_values  = 6'd9;
	endfunction

	function automatic void set_shadow_reg(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_W-1:0] data);
		case (idx)
			REG_EVAP_RATE:     sh_evap    = data[WEIGHT_W-1:0];
			REG_LEVEL_FLOOR:   sh_floor   = data;
			REG_LEVEL_CEILING: sh_ceiling = data;
			REG_BOUND_ENABLE:  sh_bound   = data[0];
			REG_INITIAL_LEVEL: sh_init    = data;
			REG_CELLS_IN_USE:  sh_cells   = data[10:0];
			REG_VALUES_IN_USE: sh_values  = data[5:0];
			default: ;
		endcase
	endfunction

	// Applies one item to the shadow table and returns the level it reports.
	function automatic ptu_result_t update_levels(ptu_cmd_t c);
		ptu_result_t        r;
		int                 rows;
		int                 cols;
		int                 pos;
		logic [LEVEL_W-1:0] v;
		logic [LEVEL_W:0]   sum;
		rows = rows_now();
		cols = cols_now();
		r    = '0;
		if (c.opc <= OP_BLEND) begin
			if (int'(c.row_idx) >= rows || int'(c.col_idx) >= cols) begin
				r.err = 1'b1;
			end else begin
				pos = int'(c.row_idx) * MAX_VALUES + int'(c.col_idx);
				v   = shadow_table[pos];
				case (c.opc)
					OP_DEPOSIT: v = mix_level(v, c.amt, sh_evap);
					OP_ADD: begin
						sum = {1'b0, v} + {1'b0, c.amt};
						v   = sum[LEVEL_W] ? LEVEL_MAX : sum[LEVEL_W-1:0];
					end
					OP_BLEND: v = mix_level(v, c.partner, c.wt);
					default: ;
				endcase
				shadow_table[pos] = v;
				r.lvl = v;
			end
		end else if (c.opc == OP_FILL || (c.opc == OP_CLAMP && sh_bound)) begin
			for (int rr = 0; rr < rows; rr++) begin
				for (int cc = 0; cc < cols; cc++) begin
					pos = rr * MAX_VALUES + cc;
					// The floor wins when the bounds are inverted.
					if (c.opc == OP_FILL)
						shadow_table[pos] = sh_init;
					else if (shadow_table[pos] < sh_floor)
						shadow_table[pos] = sh_floor;
					else if (shadow_table[pos] > sh_ceiling)
						shadow_table[pos] = sh_ceiling;
				end
			end
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		else if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic logic [LEVEL_W-1:0] rand_level();
		int p;
		p = $urandom_range(0, 99);
		if (p < 10)
			return '0;
		else if (p < 20)
			return LEVEL_MAX;
		else if (p < 40)
			return $urandom_range(0, 32'h0003_FFFF);
		return $urandom;
	endfunction

	function automatic logic [WEIGHT_W-1:0] rand_weight();
		int p;
		p = $urandom_range(0, 99);
		if (p < 10)
			return '0;
		else if (p < 20)
			return ONE_Q16;
		else if (p < 30)
			return WEIGHT_W'($urandom_range(int'(ONE_Q16) + 1, int'(WEIGHT_MAX)));
		return WEIGHT_W'($urandom_range(0, int'(ONE_Q16)));
	endfunction

	// Start is left high after acceptance so back-to-back items need no toggle.
	task automatic issue_item(ptu_cmd_t c);
		int          gap;
		ptu_result_t expected;
		gap = free_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start         <= 1'b1;
		op            <= c.opc;
		cell_req      <= c.row_idx;
		value_slot    <= c.col_idx;
		amount        <= c.amt;
		mix_weight    <= c.wt;
		partner_level <= c.partner;
		do @(posedge clk); while (busy !== 1'b0);
		expected = update_levels(c);
		pending_levels.insert(pending_levels.size(), expected);
		op_tally[c.opc]++;
		items_sent++;
	endtask

	task automatic send_op(logic [OP_W-1:0] opc, int row, int col,
			logic [LEVEL_W-1:0] amt = '0, logic [WEIGHT_W-1:0] wt = '0,
			logic [LEVEL_W-1:0] partner = '0);
		ptu_cmd_t c;
		c.opc     = opc;
		c.row_idx = 10'(row);
		c.col_idx = 5'(col);
		c.amt     = amt;
		c.wt      = wt;
		c.partner = partner;
		issue_item(c);
	endtask

	task automatic release_bus();
		@(negedge clk);
		start <= 1'b0;
	endtask

	// Registers may only change while the engine is idle.
	task automatic settle();
		release_bus();
		while (pending_levels.size() != 0 || busy !== 1'b0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		set_shadow_reg(idx, data);
	endtask

	task automatic test_reset_state();
		// Reset sizes are 81 rows by 9 columns, so the first two items sit just outside.
		send_op(OP_READ, 81, 0);
		send_op(OP_ADD, 0, 9, 32'h0001_0000);
		send_op(OP_SPARE_6, 3, 3, LEVEL_MAX, WEIGHT_MAX, LEVEL_MAX);
		send_op(OP_SPARE_7, 1023, 31);
		send_op(OP_FILL, 0, 0);
		send_op(OP_READ, 80, 8);
		send_op(OP_DEPOSIT, 0, 0, 32'h000A_0000);
	endtask

	task automatic test_full_table();
		settle();
		// Size registers beyond the table act as the full table.
		write_reg(REG_CELLS_IN_USE, 32'd2047);
		write_reg(REG_VALUES_IN_USE, 32'd63);
		write_reg(REG_INITIAL_LEVEL, LEVEL_MAX);
		send_op(OP_FILL, 0, 0);
		send_op(OP_ADD, 1023, 31, 32'd1);
		settle();
		write_reg(REG_LEVEL_CEILING, 32'hFFFF_0000);
		send_op(OP_CLAMP, 0, 0);
		send_op(OP_READ, 512, 16);
	endtask

	task automatic test_rate_extremes();
		settle();
		write_reg(REG_EVAP_RATE, 32'd0);
		send_op(OP_DEPOSIT, 1, 1, 32'd0);
		settle();
		write_reg(REG_EVAP_RATE, 32'(ONE_Q16));
		send_op(OP_DEPOSIT, 1, 1, 32'd0);
		settle();
		write_reg(REG_EVAP_RATE, 32'(WEIGHT_MAX));
		send_op(OP_DEPOSIT, 1, 1, LEVEL_MAX);
		send_op(OP_ADD, 1, 2, LEVEL_MAX);
		send_op(OP_BLEND, 1, 1, '0, '0, '0);
		send_op(OP_BLEND, 1, 1, '0, ONE_Q16, '0);
		send_op(OP_BLEND, 1, 1, '0, WEIGHT_MAX, LEVEL_MAX);
		send_op(OP_BLEND, 2, 3, '0, 17'h08000, 32'd1);
	endtask

	task automatic test_bounds();
		settle();
		write_reg(REG_CELLS_IN_USE, 32'd4);
		write_reg(REG_VALUES_IN_USE, 32'd3);
		write_reg(REG_LEVEL_FLOOR, 32'h0000_8000);
		write_reg(REG_LEVEL_CEILING, 32'h0002_0000);
		write_reg(REG_BOUND_ENABLE, 32'd0);
		write_reg(REG_INITIAL_LEVEL, 32'h0001_0000);
		send_op(OP_FILL, 0, 0);
		send_op(OP_DEPOSIT, 0, 0, 32'd0);
		send_op(OP_ADD, 3, 2, LEVEL_MAX);
		send_op(OP_CLAMP, 0, 0);
		send_op(OP_READ, 0, 0);
		settle();
		write_reg(REG_BOUND_ENABLE, 32'd1);
		send_op(OP_CLAMP, 0, 0);
		send_op(OP_READ, 3, 2);
		settle();
		write_reg(REG_LEVEL_FLOOR, 32'h0003_0000);
		write_reg(REG_LEVEL_CEILING, 32'h0001_0000);
		send_op(OP_CLAMP, 0, 0);
		send_op(OP_READ, 1, 1);
	endtask

	task automatic test_zero_size();
		settle();
		write_reg(REG_CELLS_IN_USE, 32'd0);
		send_op(OP_READ, 0, 0);
		send_op(OP_FILL, 0, 0);
		settle();
		write_reg(REG_CELLS_IN_USE, 32'd5);
		write_reg(REG_VALUES_IN_USE, 32'd0);
		send_op(OP_CLAMP, 0, 0);
		send_op(OP_ADD, 0, 0, 32'd1);
		settle();
		// Index 7 selects no register and must leave everything alone.
		write_reg(REG_SPARE, $urandom);
		write_reg(REG_VALUES_IN_USE, 32'd2);
		send_op(OP_READ, 4, 1);
	endtask

	task automatic randomize_config();
		logic [CFG_W-1:0] cells;
		logic [CFG_W-1:0] vals;
		logic [CFG_W-1:0] rate;
		logic [CFG_W-1:0] floor_lvl;
		logic [CFG_W-1:0] ceil_lvl;
		int               p;
		p = $urandom_range(0, 99);
		if (p < 4)
			cells = 0;
		else if (p < 10)
			cells = $urandom_range(MAX_CELLS, 2047);
		else
			cells = $urandom_range(1, 48);
		p = $urandom_range(0, 99);
		if (p < 4)
			vals = 0;
		else if (p < 10)
			vals = $urandom_range(MAX_VALUES, 63);
		else
			vals = $urandom_range(1, MAX_VALUES);
		rate = 32'(rand_weight());
		p = $urandom_range(0, 99);
		floor_lvl = $urandom_range(0, 32'h0004_0000);
		ceil_lvl  = (p < 15) ? rand_level() : floor_lvl + $urandom_range(0, 32'h0100_0000);
		// Bits above a narrow register's width are noise the block must drop.
		write_reg(REG_CELLS_IN_USE, cells | ($urandom << 11));
		write_reg(REG_VALUES_IN_USE, vals | ($urandom << 6));
		write_reg(REG_EVAP_RATE, rate | ($urandom << WEIGHT_W));
		write_reg(REG_LEVEL_FLOOR, floor_lvl);
		write_reg(REG_LEVEL_CEILING, ceil_lvl);
		write_reg(REG_BOUND_ENABLE, $urandom);
		write_reg(REG_INITIAL_LEVEL, rand_level());
	endtask

	function automatic ptu_cmd_t random_cmd(bit sweeps_ok);
		ptu_cmd_t c;
		int       p;
		int       rows;
		int       cols;
		rows      = rows_now();
		cols      = cols_now();
		c.amt     = rand_level();
		c.wt      = rand_weight();
		c.partner = rand_level();
		c.row_idx = 10'($urandom);
		c.col_idx = 5'($urandom);
		p = $urandom_range(0, 99);
		if (p < 15)
			c.opc = OP_READ;
		else if (p < 37)
			c.opc = OP_DEPOSIT;
		else if (p < 60)
			c.opc = OP_ADD;
		else if (p < 82)
			c.opc = OP_BLEND;
		else if (p < 88)
			c.opc = OP_CLAMP;
		else if (p < 91)
			c.opc = OP_FILL;
		else if (p < 93)
			c.opc = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
		else
			c.opc = OP_W'($urandom_range(int'(OP_READ), int'(OP_BLEND)));
		if (!sweeps_ok && (c.opc == OP_CLAMP || c.opc == OP_FILL))
			c.opc = OP_READ;
		if (p < 82 && rows > 0 && cols > 0) begin
			c.row_idx = 10'($urandom_range(0, rows - 1));
			c.col_idx = 5'($urandom_range(0, cols - 1));
		end else if (p >= 93) begin
			if (rows < MAX_CELLS && ($urandom_range(0, 1) || cols >= MAX_VALUES))
				c.row_idx = 10'($urandom_range(rows, MAX_CELLS - 1));
			else if (cols < MAX_VALUES)
				c.col_idx = 5'($urandom_range(cols, MAX_VALUES - 1));
		end
		return c;
	endfunction

	task automatic test_random_phases();
		bit sweeps_ok;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			settle();
			randomize_config();
			sweeps_ok = rows_now() * cols_now() <= SWEEP_BUDGET;
			free_gaps = ($urandom_range(0, 3) != 0);
			repeat (PHASE_ITEMS) issue_item(random_cmd(sweeps_ok));
		end
		free_gaps = 1'b1;
	endtask

	always @(posedge clk) begin : result_check
		ptu_result_t want;
		if (arst_n && done === 1'b1) begin
			results_seen++;
			if (pending_levels.size() == 0) begin
				fault_count++;
				if (fault_count <= MAX_REPORTS)
					$display("Result %0d with nothing pending: level %h index_error %b",
						results_seen, level, index_error);
			end else begin
				want = pending_levels.pop_front();
				if (level !== want.lvl || index_error !== want.err) begin
					fault_count++;
					if (fault_count <= MAX_REPORTS)
						$display("Result %0d: level exp %h got %h, index_error exp %b got %b",
							results_seen, want.lvl, level, want.err, index_error);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Run stopped at the cycle limit with %0d results pending",
				pending_levels.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin : main_flow
		int waited;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		start         = 1'b0;
		op            = '0;
		cell_req      = '0;
		value_slot    = '0;
		amount        = '0;
		mix_weight    = '0;
		partner_level = '0;
		foreach (op_tally[i]) op_tally[i] = 0;
		reset_shadow();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_full_table();
		test_rate_extremes();
		test_bounds();
		test_zero_size();
		test_random_phases();

		release_bus();
		waited = 0;
		while (pending_levels.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_levels.size() != 0) begin
			$display("%0d expected results never arrived", pending_levels.size());
			fault_count += pending_levels.size();
		end

		$display(
			"%0d items: read %0d, deposit %0d, add %0d, blend %0d, clamp %0d, fill %0d, other %0d",
			items_sent, op_tally[OP_READ], op_tally[OP_DEPOSIT], op_tally[OP_ADD],
			op_tally[OP_BLEND], op_tally[OP_CLAMP], op_tally[OP_FILL],
			op_tally[OP_SPARE_6] + op_tally[OP_SPARE_7]);
		$display(
			"Checked %0d results over %0d cycles and %0d register phases, %0d mismatches",
			results_seen, cycle_count, RANDOM_PHASES, fault_count);
		if (fault_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/ptu_pkg.sv
rtl/ptu_ram.sv
rtl/ptu_mac.sv
rtl/pheromone_table_update_engine.sv
dv/tb_top.sv
